// ----- rtl/xpfc_pkg.sv -----
// Package: shared types and constants for the XOR packet frame checker.
`default_nettype none

package xpfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned STATUS_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] MIN_FRAME_BYTES = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] FRAME_OVERHEAD  = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] IDX_MAGIC       = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] IDX_LEN_LO      = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] IDX_LEN_HI      = COUNT_W'(4);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_MAGIC  = 3'd2,
        ST_LENGTH = 3'd3,
        ST_CHECK  = 3'd4
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] payload_length;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/xpfc_if.sv -----
// Interfaces: frame byte, result and configuration channels.
`default_nettype none

interface xpfc_frame_if;
    logic                      valid;
    logic                      ready;
    logic [xpfc_pkg::BYTE_W-1:0] data_byte;
    logic                      frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface xpfc_result_if;
    logic                        valid;
    logic                        ready;
    logic [xpfc_pkg::STATUS_W-1:0] status;
    logic [xpfc_pkg::LEN_W-1:0]    payload_length;

    modport source (output valid, output status, output payload_length, input ready);
    modport sink   (input valid, input status, input payload_length, output ready);
endinterface

interface xpfc_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [xpfc_pkg::BYTE_W-1:0] magic_value;

    modport source (output valid, output magic_value, input ready);
    modport sink   (input valid, input magic_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/xpfc_in_stage.sv -----
// Input register: holds one frame byte item until the core consumes it.
`default_nettype none

module xpfc_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire xpfc_pkg::in_item_t in_item,
    input  wire logic               advance,
    output logic                    item_valid,
    output xpfc_pkg::in_item_t      item
);
    import xpfc_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;
    logic     accept;

    assign in_ready   = !valid_reg || advance;
    assign accept     = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/xpfc_frame_core.sv -----
// Frame core: magic register, per-frame count/XOR/length state and status checks.
`default_nettype none

module xpfc_frame_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [xpfc_pkg::BYTE_W-1:0]   cfg_data,
    input  wire logic                          item_valid,
    input  wire xpfc_pkg::in_item_t            item,
    input  wire logic                          out_free,
    output logic                               advance,
    output logic                               res_push,
    output xpfc_pkg::result_t                  result
);
    import xpfc_pkg::*;

    logic [BYTE_W-1:0]  magic_value_reg;
    logic [COUNT_W-1:0] byte_count_reg,   byte_count_next;
    logic [BYTE_W-1:0]  running_xor_reg,  running_xor_next;
    logic               magic_seen_reg,   magic_seen_next;
    logic [LEN_W-1:0]   length_field_reg, length_field_next;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] expected_count;
    status_t            status;

    assign advance  = item_valid && (!item.frame_end || out_free);
    assign res_push = advance && item.frame_end;

    always_comb
    begin
        magic_seen_next   = magic_seen_reg;
        length_field_next = length_field_reg;
        if (byte_count_reg == IDX_MAGIC)
        begin
            magic_seen_next = (item.data_byte == magic_value_reg);
        end
        else if (byte_count_reg == IDX_LEN_LO)
        begin
            length_field_next = {length_field_reg[LEN_W-1:BYTE_W], item.data_byte};
        end
        else if (byte_count_reg == IDX_LEN_HI)
        begin
            length_field_next = {item.data_byte, length_field_reg[BYTE_W-1:0]};
        end
        running_xor_next = running_xor_reg ^ item.data_byte;
        count_inc        = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                         : byte_count_reg + 1'b1;
        byte_count_next  = count_inc;
        expected_count   = {1'b0, length_field_next} + FRAME_OVERHEAD;

        priority if (count_inc < MIN_FRAME_BYTES)
        begin
            status = ST_SHORT;
        end
        else if (!magic_seen_next)
        begin
            status = ST_MAGIC;
        end
        else if (count_inc != expected_count)
        begin
            status = ST_LENGTH;
        end
        else if (running_xor_next != '0)
        begin
            status = ST_CHECK;
        end
        else
        begin
            status = ST_OK;
        end

        if (item.frame_end)
        begin
            byte_count_next   = '0;
            running_xor_next  = '0;
            magic_seen_next   = 1'b0;
            length_field_next = '0;
        end
    end

    always_comb
    begin
        result.status         = status;
        result.payload_length = (byte_count_reg == IDX_LEN_HI)
                              ? {item.data_byte, length_field_reg[BYTE_W-1:0]}
                              : length_field_reg;
        if (byte_count_reg == IDX_LEN_LO)
        begin
            result.payload_length = {length_field_reg[LEN_W-1:BYTE_W], item.data_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_value_reg  <= '0;
            byte_count_reg   <= '0;
            running_xor_reg  <= '0;
            magic_seen_reg   <= 1'b0;
            length_field_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                magic_value_reg <= cfg_data;
            end
            if (advance)
            begin
                byte_count_reg   <= byte_count_next;
                running_xor_reg  <= running_xor_next;
                magic_seen_reg   <= magic_seen_next;
                length_field_reg <= length_field_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/xpfc_out_stage.sv -----
// Result register: holds one status item until the sink takes it.
`default_nettype none

module xpfc_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_push,
    input  wire xpfc_pkg::result_t result,
    output logic                   out_free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output xpfc_pkg::result_t      out_result
);
    import xpfc_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/xor_packet_frame_checker_top.sv -----
// Top level: XOR packet frame checker, input register, core and result register.
//
//   channel  dir  payload                       notes
//   frame    in   data_byte[7:0], frame_end     one byte item per handshake
//   result   out  status[2:0], payload_length   one item per frame_end byte
//   cfg      in   magic_value[7:0]              always ready
//
// One byte item per cycle sustained unless a frame_end byte waits for a full
// result register; each result is registered from its frame_end byte.
// Both stages are single registers, so a stalled result holds back only the
// next frame_end byte in the input register.
// Reset clears the magic register to zero and all frame state.
`default_nettype none

module xor_packet_frame_checker_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    xpfc_frame_if.sink    frame,
    xpfc_result_if.source result,
    xpfc_cfg_if.sink      cfg
);
    import xpfc_pkg::*;

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     res_push;
    logic     out_free;
    result_t  core_result;
    result_t  out_result;

    assign in_item.data_byte = frame.data_byte;
    assign in_item.frame_end = frame.frame_end;
    assign cfg.ready         = 1'b1;

    xpfc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (frame.valid),
        .in_ready   (frame.ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    xpfc_frame_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.magic_value),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .advance    (advance),
        .res_push   (res_push),
        .result     (core_result)
    );

    xpfc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_push   (res_push),
        .result     (core_result),
        .out_free   (out_free),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_result (out_result)
    );

    assign result.status         = out_result.status;
    assign result.payload_length = out_result.payload_length;

endmodule

`default_nettype wire

// ----- bench/tb_xor_packet_frame_checker_top.sv -----
// Testbench: xor_packet_frame_checker_top, directed frames then random frames with flow control.
module tb_xor_packet_frame_checker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xpfc_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES   = 440;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [7:0]       data;
        logic             last;
        logic             pinned;
        status_t          st;
        logic [LEN_W-1:0] len;
    } row_t;

    typedef struct packed {
        logic    fixed;
        result_t res;
    } pinned_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    xpfc_frame_if  frame_ch ();
    xpfc_result_if res_ch ();
    xpfc_cfg_if    cfg_ch ();

    xor_packet_frame_checker_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #10 clk = ~clk;

    // directed frames; magic register is 0 out of reset
    row_t plan[$] = '{
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, ST_SHORT,  16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h01, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h02, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h03, 1'b1, 1'b1, ST_OK,     16'h0000},
        // short frame, only the low length byte arrives
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h5A, 1'b1, 1'b1, ST_SHORT,  16'h005A},
        '{ROW_CFG,  8'hFF, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, ST_LENGTH, 16'hFFFF},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h01, 1'b1, 1'b1, ST_CHECK,  16'h0000},
        // magic rewritten after byte 0 went in: byte 0 still judged against the old value
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_CFG,  8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_OK,     16'h0000},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, ST_MAGIC,  16'h0000}
    };

    result_t expected_status_q[$];
    pinned_t pinned_q[$];

    logic [COUNT_W-1:0] fr_count    = '0;
    logic [7:0]         fr_xor      = '0;
    logic               fr_magic_ok = 1'b0;
    logic [LEN_W-1:0]   fr_len      = '0;
    logic [7:0]         magic_copy  = '0;

    int mismatch_count = 0;
    int status_tally[5] = '{default: 0};
    int bytes_sent = 0;
    int tx_pct = 0;
    int rx_pct = 0;
    logic hold_req = 1'b0;
    logic [7:0] cur_magic = 8'h00;

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void advance_frame_state(input logic [7:0] b, input logic last);
        result_t r;
        pinned_t p;
        if (fr_count == IDX_MAGIC)
            fr_magic_ok = (b == magic_copy);
        else if (fr_count == IDX_LEN_LO)
            fr_len[7:0] = b;
        else if (fr_count == IDX_LEN_HI)
            fr_len[15:8] = b;
        fr_xor = fr_xor ^ b;
        if (fr_count != COUNT_MAX)
            fr_count = fr_count + 1'b1;
        if (last)
        begin
            if (fr_count < MIN_FRAME_BYTES)
                r.status = ST_SHORT;
            else if (!fr_magic_ok)
                r.status = ST_MAGIC;
            else if (fr_count != FRAME_OVERHEAD + COUNT_W'(fr_len))
                r.status = ST_LENGTH;
            else if (fr_xor != 8'h00)
                r.status = ST_CHECK;
            else
                r.status = ST_OK;
            r.payload_length = fr_len;
            if (pinned_q.size() != 0)
            begin
                p = pinned_q.pop_front();
                if (p.fixed)
                    r = p.res;
            end
            expected_status_q.push_back(r);
            fr_count    = '0;
            fr_xor      = '0;
            fr_magic_ok = 1'b0;
            fr_len      = '0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                magic_copy = cfg_ch.magic_value;
            if (frame_ch.valid && frame_ch.ready)
                advance_frame_state(frame_ch.data_byte, frame_ch.frame_end);
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_status_q.size() == 0)
                report_mismatch($sformatf("result status %0d len %0d with nothing expected",
                                          res_ch.status, res_ch.payload_length));
            else
            begin
                e = expected_status_q.pop_front();
                status_tally[int'(e.status)]++;
                if (res_ch.status !== e.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              res_ch.status, e.status));
                if (res_ch.payload_length !== e.payload_length)
                    report_mismatch($sformatf("payload_length %0d, expected %0d",
                                              res_ch.payload_length, e.payload_length));
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        res_ch.ready = 1'b1;
        forever
        begin
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            res_ch.ready <= !(rx_pct != 0 && $urandom_range(99) < rx_pct);
            @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((frame_ch.valid && frame_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (tx_pct != 0 && $urandom_range(99) < tx_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid     <= 1'b1;
        frame_ch.data_byte <= b;
        frame_ch.frame_end <= last;
        do @(posedge clk); while (!frame_ch.ready);
        bytes_sent++;
    endtask

    task automatic settle_frames();
        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_status_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_magic(input logic [7:0] v);
        settle_frames();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.magic_value <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_magic = v;
    endtask

    task automatic send_random_frame();
        logic [7:0] fb[$];
        logic [15:0] plen;
        int unsigned pick;
        int unsigned cut;
        logic [7:0] sum;
        pick = $urandom_range(99);
        if (pick >= 90)
        begin
            repeat ($urandom_range(1, 8)) fb.push_back(8'($urandom));
        end
        else
        begin
            plen = ($urandom_range(9) == 0) ? 16'($urandom_range(300))
                                            : 16'($urandom_range(12));
            fb.push_back(cur_magic);
            fb.push_back(8'($urandom));
            fb.push_back(8'($urandom));
            fb.push_back(plen[7:0]);
            fb.push_back(plen[15:8]);
            repeat (plen) fb.push_back(8'($urandom));
            sum = 8'h00;
            foreach (fb[i]) sum = sum ^ fb[i];
            fb.push_back(sum);
            if (pick >= 70 && pick < 78)
                fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
            else if (pick >= 78 && pick < 85)
            begin
                cut = $urandom_range(fb.size() - 1);
                fb[cut] = fb[cut] ^ 8'(1 << $urandom_range(7));
            end
            else if (pick >= 85 && pick < 88)
            begin
                cut = $urandom_range(1, fb.size() - 1);
                while (fb.size() > cut) void'(fb.pop_back());
            end
            else if (pick >= 88)
                repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom));
        end
        foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
    endtask

    initial
    begin : stimulus
        pinned_t p;
        int target;
        frame_ch.valid     = 1'b0;
        frame_ch.data_byte = '0;
        frame_ch.frame_end = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.magic_value = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_magic(plan[i].data);
            else
            begin
                if (plan[i].last)
                begin
                    p.fixed              = plan[i].pinned;
                    p.res.status         = plan[i].st;
                    p.res.payload_length = plan[i].len;
                    pinned_q.push_back(p);
                end
                send_byte(plan[i].data, plan[i].last);
            end
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            write_magic(ph == 0 ? 8'h00 : 8'($urandom));
            case (ph)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 55; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 55; end
                default: begin tx_pct = 14; rx_pct = 14; end
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) send_random_frame();
            if (ph == 0)
            begin
                // results back up while short frames keep coming
                hold_req = 1'b1;
                repeat (40) send_byte(8'($urandom), 1'b1);
            end
        end

        settle_frames();

        $display("Covered %0d bytes: ok %0d, short %0d, bad magic %0d, length %0d, checksum %0d",
                 bytes_sent, status_tally[0], status_tally[1], status_tally[2],
                 status_tally[3], status_tally[4]);
        $display("Idle phases none/sender/receiver/both, one result hold-off, payloads to 300");
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
